// File: hw/rtl/pmpt_pkg.sv
// Shared types and constants for the pose matched point transform.
`default_nettype none
package pmpt_pkg;

  localparam int HISTORY_DEPTH_DEF = 512;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] STARTUP_SKIP_RESET = 8'd5;

  typedef enum logic [1:0] {
    KIND_POSE  = 2'd0,
    KIND_SCAN  = 2'd1,
    KIND_POINT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_USE_HISTORY  = 2'd0,
    REG_STARTUP_SKIP = 2'd1,
    REG_SPARE2       = 2'd2,
    REG_SPARE3       = 2'd3
  } reg_index_t;

  // sines and cosines in Q1.14
  typedef struct packed {
    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
  } trig_t;

  typedef struct packed {
    logic [47:0]        time_us;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } pose_t;

endpackage
`default_nettype wire

// File: hw/rtl/pmpt_trig.sv
// Iterative sine/cosine unit: one shared multiplier under a small sequencer.
`default_nettype none
module pmpt_trig (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);

  localparam logic signed [16:0] PiQ13 = 17'sd25736;
  localparam logic signed [16:0] HalfPiQ13 = 17'sd12868;
  localparam logic [30:0] One30 = 31'h4000_0000;

  typedef enum logic [8:0] {
    T_IDLE = 9'b000000001,
    T_SQ   = 9'b000000010,
    T_X2   = 9'b000000100,
    T_RM   = 9'b000001000,
    T_FX   = 9'b000010000,
    T_QM   = 9'b000100000,
    T_QC   = 9'b001000000,
    T_FIN  = 9'b010000000,
    T_RES  = 9'b100000000
  } tstate_t;

  function automatic logic [6:0] div_const(input logic cos_sel, input logic [1:0] j);
    logic [6:0] d;
    unique case ({cos_sel, j})
      3'd0: d = 7'd72;
      3'd1: d = 7'd42;
      3'd2: d = 7'd20;
      3'd3: d = 7'd6;
      3'd4: d = 7'd90;
      3'd5: d = 7'd56;
      3'd6: d = 7'd30;
      3'd7: d = 7'd12;
    endcase
    return d;
  endfunction

  // floor(2^33 / d); the estimate is at most one short
  function automatic logic [30:0] recip(input logic cos_sel, input logic [1:0] j);
    logic [30:0] r;
    unique case ({cos_sel, j})
      3'd0: r = 31'((64'd1 << 33) / 64'd72);
      3'd1: r = 31'((64'd1 << 33) / 64'd42);
      3'd2: r = 31'((64'd1 << 33) / 64'd20);
      3'd3: r = 31'((64'd1 << 33) / 64'd6);
      3'd4: r = 31'((64'd1 << 33) / 64'd90);
      3'd5: r = 31'((64'd1 << 33) / 64'd56);
      3'd6: r = 31'((64'd1 << 33) / 64'd30);
      3'd7: r = 31'((64'd1 << 33) / 64'd12);
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] round_q14(input logic [31:0] mag, input logic neg);
    logic [32:0] s;
    logic [15:0] r;
    s = {1'b0, mag} + 33'h0_0000_8000;
    r = s[31:16];
    return neg ? -r : r;
  endfunction

  tstate_t     state;
  logic [30:0] u;
  logic [31:0] x2;
  logic [31:0] q;
  logic [30:0] t;
  logic [63:0] prod;
  logic        fsel;
  logic [1:0]  j;
  logic        sneg;
  logic        cneg;

  logic signed [16:0] a_ext;
  logic signed [16:0] a_fold;
  logic               cneg_next;
  logic [16:0]        a_mag;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [6:0]         dv;
  logic [30:0]        est;
  logic [37:0]        est_d;
  logic [31:0]        rem;
  logic [30:0]        quot;
  logic [30:0]        h;

  always_comb begin
    a_ext = {angle[15], angle};
    cneg_next = 1'b1;
    if (a_ext > HalfPiQ13) begin
      a_fold = PiQ13 - a_ext;
    end else if (a_ext < -HalfPiQ13) begin
      a_fold = -PiQ13 - a_ext;
    end else begin
      a_fold = a_ext;
      cneg_next = 1'b0;
    end
    a_mag = a_fold[16] ? 17'(-a_fold) : 17'(a_fold);
  end

  always_comb begin
    mul_a = {1'b0, u};
    mul_b = {1'b0, t};
    unique case (state)
      T_SQ:    mul_b = {1'b0, u};
      T_RM: begin
        mul_a = q;
        mul_b = {1'b0, recip(fsel, j)};
      end
      T_QM:    mul_a = x2;
      T_FIN:   mul_a = fsel ? x2 : {1'b0, u};
      default: ;
    endcase
  end

  always_comb begin
    dv    = div_const(fsel, j);
    est   = prod[63:33];
    est_d = est * dv;
    rem   = q - est_d[31:0];
    quot  = (rem >= 32'(dv)) ? est + 31'd1 : est;
    h     = prod[61:31];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == T_RES) && fsel;
      unique case (state)
        T_IDLE: begin
          if (start) begin
            u     <= {a_mag[13:0], 17'd0};
            sneg  <= a_fold[16];
            cneg  <= cneg_next;
            state <= T_SQ;
          end
        end
        T_SQ: state <= T_X2;
        T_X2: begin
          x2    <= prod[61:30];
          q     <= prod[61:30];
          fsel  <= 1'b0;
          j     <= 2'd0;
          state <= T_RM;
        end
        T_RM: state <= T_FX;
        T_FX: begin
          t <= One30 - quot;
          if (j == 2'd3) begin
            state <= T_FIN;
          end else begin
            j     <= j + 2'd1;
            state <= T_QM;
          end
        end
        T_QM: state <= T_QC;
        T_QC: begin
          q     <= prod[61:30];
          state <= T_RM;
        end
        T_FIN: state <= T_RES;
        T_RES: begin
          if (!fsel) begin
            sin_q <= round_q14(prod[61:30], sneg);
            fsel  <= 1'b1;
            j     <= 2'd0;
            q     <= x2;
            state <= T_RM;
          end else begin
            // cosine below zero before the fold flips the sign once more
            if (h > One30) begin
              cos_q <= round_q14(32'(h - One30), !cneg);
            end else begin
              cos_q <= round_q14(32'(One30 - h), cneg);
            end
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pmpt_xform.sv
// Point rotation and translation over one shared multiply-accumulate.
`default_nettype none
module pmpt_xform (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] cz,
  input  pmpt_pkg::trig_t    trig,
  input  logic signed [31:0] off_x,
  input  logic signed [31:0] off_y,
  input  logic signed [31:0] off_z,
  output logic               done,
  output logic [31:0]        res_x,
  output logic [31:0]        res_y,
  output logic [31:0]        res_z
);

  logic               busy;
  logic [2:0]         step;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic signed [53:0] acc;
  logic signed [35:0] y1;
  logic signed [35:0] z1;
  logic signed [35:0] x2r;
  logic signed [35:0] z2;

  logic signed [35:0] op_a;
  logic signed [15:0] op_b;
  logic               op_sub;
  logic signed [51:0] prod;
  logic signed [53:0] sum;
  logic signed [53:0] sum_r;
  logic signed [35:0] rnd;

  always_comb begin
    op_sub = 1'b0;
    unique case (step)
      3'd0: begin op_a = 36'(py); op_b = trig.cr; end
      3'd1: begin op_a = 36'(pz); op_b = trig.sr; op_sub = 1'b1; end
      3'd2: begin op_a = 36'(py); op_b = trig.sr; end
      3'd3: begin op_a = 36'(pz); op_b = trig.cr; end
      3'd4: begin op_a = 36'(px); op_b = trig.cp; end
      3'd5: begin op_a = z1;      op_b = trig.sp; end
      3'd6: begin op_a = z1;      op_b = trig.cp; end
      3'd7: begin op_a = 36'(px); op_b = trig.sp; op_sub = 1'b1; end
    endcase
    prod  = op_a * op_b;
    sum   = op_sub ? acc - 54'(prod) : acc + 54'(prod);
    // floor((v + 2^13) / 2^14)
    sum_r = sum + 54'sd8192;
    rnd   = sum_r[49:14];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 3'd7);
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px <= cx;
      py <= cy;
      pz <= cz;
    end else if (busy) begin
      if (!step[0]) begin
        acc <= 54'(prod);
      end else begin
        unique case (step[2:1])
          2'd0: y1  <= rnd;
          2'd1: z1  <= rnd;
          2'd2: x2r <= rnd;
          2'd3: z2  <= rnd;
        endcase
      end
    end
  end

  assign res_x = x2r[31:0] + off_x;
  assign res_y = y1[31:0] + off_y;
  assign res_z = z2[31:0] + off_z;

endmodule
`default_nettype wire

// File: hw/rtl/pose_matched_point_transform.sv
// Top level: pose ring, scan sequencer, trig and point units, output register.
//
//  channel | signals                                   | handshake
//  in      | kind time_us coord_x/y/z tilt_roll/pitch  | in_valid / in_stall
//          | point_valid last_point                    |
//  out     | out_x/y/z stamp_us out_last               | out_valid / out_stall
//  cfg     | cfg_write cfg_index cfg_data              | write enable, no wait
//
// A pose sample is written straight into the ring. A point runs through the shared
// multiply-accumulate. A scan start steps the search over the ring slots (one memory
// read port), then runs two angles, roll and pitch, through the shared trig multiplier.
// Reset is synchronous; the ring needs no clearing. in_stall is high while an
// item is in work or a result waits for the output register; a result held in
// the output register does not block the next item.
`default_nettype none
module pose_matched_point_transform #(
  parameter int HISTORY_DEPTH = pmpt_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       kind,
  input  logic [47:0]                      time_us,
  input  logic signed [31:0]               coord_x,
  input  logic signed [31:0]               coord_y,
  input  logic signed [31:0]               coord_z,
  input  logic signed [15:0]               tilt_roll,
  input  logic signed [15:0]               tilt_pitch,
  input  logic                             point_valid,
  input  logic                             last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_x,
  output logic signed [31:0]               out_y,
  output logic signed [31:0]               out_z,
  output logic [47:0]                      stamp_us,
  output logic                             out_last,
  input  logic                             cfg_write,
  input  logic [pmpt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pmpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] IdxLast = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRD  = 9'b000000010,
    S_SCMP = 9'b000000100,
    S_KRD  = 9'b000001000,
    S_KLAT = 9'b000010000,
    S_TRR  = 9'b000100000,
    S_TRP  = 9'b001000000,
    S_PNT  = 9'b010000000,
    S_OWT  = 9'b100000000
  } state_t;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == IdxLast) ? '0 : i + 1'b1;
  endfunction

  state_t          state;
  logic [AW-1:0]   write_index;
  logic [AW-1:0]   read_index;
  logic            have_pose;
  logic [7:0]      skip_count;
  logic            started;
  logic            scan_active;
  logic            use_history;
  logic [7:0]      startup_skip;
  pmpt_pkg::trig_t trig_values;
  logic [47:0]     scan_time;
  logic [47:0]     scan_stamp;
  logic signed [31:0] off_x;
  logic signed [31:0] off_y;
  logic signed [31:0] off_z;
  logic signed [15:0] pitch_hold;
  logic            last_hold;

  pmpt_pkg::pose_t mem [HISTORY_DEPTH];
  pmpt_pkg::pose_t mem_q;
  pmpt_pkg::pose_t mem_d;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   widx_new;

  logic               in_acc;
  pmpt_pkg::kind_t    kind_c;
  logic               out_free;
  logic               load_out;
  logic               trig_start;
  logic               trig_done;
  logic signed [15:0] trig_angle;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;
  logic               xf_start;
  logic               xf_done;
  logic [31:0]        res_x;
  logic [31:0]        res_y;
  logic [31:0]        res_z;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign kind_c   = pmpt_pkg::kind_t'(kind);
  assign widx_new = have_pose ? next_slot(write_index) : '0;
  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && ((state == S_PNT && xf_done) || state == S_OWT);
  assign rd_addr  = (state == S_SRD) ? next_slot(read_index)
                  : (use_history ? read_index : write_index);
  assign trig_start = (state == S_KLAT) || (state == S_TRR && trig_done);
  assign trig_angle = (state == S_KLAT) ? mem_q.roll : pitch_hold;
  assign xf_start = in_acc && kind_c == pmpt_pkg::KIND_POINT && scan_active && point_valid;

  assign mem_d = '{time_us: time_us, x: coord_x, y: coord_y, z: coord_z,
                   roll: tilt_roll, pitch: tilt_pitch};

  always_ff @(posedge clk) begin
    if (in_acc && kind_c == pmpt_pkg::KIND_POSE) begin
      mem[widx_new] <= mem_d;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_index  <= '0;
      read_index   <= '0;
      have_pose    <= 1'b0;
      skip_count   <= 8'd0;
      started      <= 1'b0;
      scan_active  <= 1'b0;
      use_history  <= 1'b0;
      startup_skip <= pmpt_pkg::STARTUP_SKIP_RESET;
      out_valid    <= 1'b0;
      trig_values  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (pmpt_pkg::reg_index_t'(cfg_index))
          pmpt_pkg::REG_USE_HISTORY:  use_history  <= cfg_data[0];
          pmpt_pkg::REG_STARTUP_SKIP: startup_skip <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (kind_c)
              pmpt_pkg::KIND_POSE: begin
                write_index <= widx_new;
                have_pose   <= 1'b1;
              end
              pmpt_pkg::KIND_SCAN: begin
                if (!started) begin
                  if (skip_count >= startup_skip) started <= 1'b1;
                  else skip_count <= skip_count + 8'd1;
                  scan_active <= 1'b0;
                end else if (!have_pose) begin
                  scan_active <= 1'b0;
                end else begin
                  state <= S_SRD;
                end
              end
              pmpt_pkg::KIND_POINT: begin
                if (scan_active) begin
                  if (last_point) scan_active <= 1'b0;
                  if (point_valid) state <= S_PNT;
                end
              end
              default: ;
            endcase
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          // step toward the newest sample still older than the scan
          if (read_index != write_index && mem_q.time_us < scan_time) begin
            read_index <= next_slot(read_index);
            state      <= S_SRD;
          end else begin
            state <= S_KRD;
          end
        end
        S_KRD:  state <= S_KLAT;
        S_KLAT: state <= S_TRR;
        S_TRR: begin
          if (trig_done) begin
            trig_values.sr <= sin_q;
            trig_values.cr <= cos_q;
            state          <= S_TRP;
          end
        end
        S_TRP: begin
          if (trig_done) begin
            trig_values.sp <= sin_q;
            trig_values.cp <= cos_q;
            scan_active    <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_PNT: begin
          if (xf_done) state <= out_free ? S_IDLE : S_OWT;
        end
        S_OWT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && kind_c == pmpt_pkg::KIND_SCAN) scan_time <= time_us;
    if (in_acc && kind_c == pmpt_pkg::KIND_POINT) last_hold <= last_point;
    if (state == S_KLAT) begin
      scan_stamp <= mem_q.time_us;
      off_x      <= mem_q.x;
      off_y      <= mem_q.y;
      off_z      <= mem_q.z;
      pitch_hold <= mem_q.pitch;
    end
    if (load_out) begin
      out_x    <= res_x;
      out_y    <= res_y;
      out_z    <= res_z;
      stamp_us <= scan_stamp;
      out_last <= last_hold;
    end
  end

  pmpt_trig u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (trig_angle),
    .done  (trig_done),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  pmpt_xform u_xform (
    .clk   (clk),
    .rst   (rst),
    .start (xf_start),
    .cx    (coord_x),
    .cy    (coord_y),
    .cz    (coord_z),
    .trig  (trig_values),
    .off_x (off_x),
    .off_y (off_y),
    .off_z (off_z),
    .done  (xf_done),
    .res_x (res_x),
    .res_y (res_y),
    .res_z (res_z)
  );

endmodule
`default_nettype wire

// File: verif/tb_pose_matched_point_transform.sv
// Self-checking testbench for the pose matched point transform: directed and random items.
`default_nettype none
module tb_pose_matched_point_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int SETTLE = 1200;      // longest scan start: full ring search plus two angles
  localparam int IDLE_LIMIT = 6000;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    pmpt_pkg::kind_t    kind;
    logic [47:0]        tus;
    logic signed [31:0] x, y, z;
    logic signed [15:0] roll, pitch;
    logic               pv, lp;
  } item_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [47:0]        stamp;
    logic               last;
  } point_res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [1:0] kind = '0;
  logic [47:0] time_us = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic signed [15:0] tilt_roll = '0, tilt_pitch = '0;
  logic point_valid = 0, last_point = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [47:0] stamp_us;
  logic out_last;
  logic cfg_write = 0;
  logic [pmpt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pmpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pose_matched_point_transform #(.HISTORY_DEPTH(DEPTH)) DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [47:0] ring_t [DEPTH];
  logic signed [31:0] ring_x [DEPTH], ring_y [DEPTH], ring_z [DEPTH];
  logic signed [15:0] ring_roll [DEPTH], ring_pitch [DEPTH];
  logic [AW-1:0] wr_idx, rd_idx;
  logic [7:0] skips_seen, skip_cfg;
  logic hist_on, have_pose, started, in_scan;
  int sin_r, cos_r, sin_p, cos_p;
  logic signed [31:0] off_x, off_y, off_z;
  logic [47:0] scan_stamp;
  point_res_t expected_points[$];

  int fails = 0;
  int burst_left = 0;
  logic [47:0] now_t = 48'd1000;

  function automatic int round_q14(longint unsigned mag, bit neg);
    int r;
    r = int'((mag + (64'd1 << 15)) >> 16);
    return neg ? -r : r;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output int s, output int c);
    int a;
    bit cneg, sneg;
    longint unsigned one, u, x2, t, h;
    one = 64'd1 << 30;
    a = ang;
    cneg = 0;
    if (a > HALF_PI_Q13) begin
      a = PI_Q13 - a;
      cneg = 1;
    end else if (a < -HALF_PI_Q13) begin
      a = -PI_Q13 - a;
      cneg = 1;
    end
    sneg = a < 0;
    u = longint'(sneg ? -a : a) << 17;
    x2 = (u * u) >> 30;
    t = one - x2 / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = round_q14((u * t) >> 30, sneg);
    t = one - x2 / 90;
    t = one - ((x2 * t) >> 30) / 56;
    t = one - ((x2 * t) >> 30) / 30;
    t = one - ((x2 * t) >> 30) / 12;
    h = ((x2 * t) >> 30) / 2;
    if (h > one) c = round_q14(h - one, !cneg);
    else c = round_q14(one - h, cneg);
  endfunction

  function automatic longint rnd_sh14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic void predict_item(item_t it);
    logic [AW-1:0] k;
    longint y1, z1, x2, z2;
    point_res_t r;
    case (it.kind)
      pmpt_pkg::KIND_POSE: begin
        wr_idx = have_pose ? wr_idx + 1'b1 : '0;
        ring_t[wr_idx] = it.tus;
        ring_x[wr_idx] = it.x;
        ring_y[wr_idx] = it.y;
        ring_z[wr_idx] = it.z;
        ring_roll[wr_idx] = it.roll;
        ring_pitch[wr_idx] = it.pitch;
        have_pose = 1;
      end
      pmpt_pkg::KIND_SCAN: begin
        if (!started) begin
          if (skips_seen >= skip_cfg) started = 1;
          else skips_seen = skips_seen + 8'd1;
          in_scan = 0;
        end else if (!have_pose) begin
          in_scan = 0;
        end else begin
          while (rd_idx != wr_idx && ring_t[rd_idx + 1'b1] < it.tus) rd_idx = rd_idx + 1'b1;
          k = hist_on ? rd_idx : wr_idx;
          scan_stamp = ring_t[k];
          off_x = ring_x[k];
          off_y = ring_y[k];
          off_z = ring_z[k];
          sin_cos(ring_roll[k], sin_r, cos_r);
          sin_cos(ring_pitch[k], sin_p, cos_p);
          in_scan = 1;
        end
      end
      pmpt_pkg::KIND_POINT: begin
        if (in_scan) begin
          if (it.lp) in_scan = 0;
          if (it.pv) begin
            y1 = rnd_sh14(longint'(it.y) * cos_r - longint'(it.z) * sin_r);
            z1 = rnd_sh14(longint'(it.y) * sin_r + longint'(it.z) * cos_r);
            x2 = rnd_sh14(longint'(it.x) * cos_p + z1 * sin_p);
            z2 = rnd_sh14(z1 * cos_p - longint'(it.x) * sin_p);
            r.x = 32'(x2 + off_x);
            r.y = 32'(y1 + off_y);
            r.z = 32'(z2 + off_z);
            r.stamp = scan_stamp;
            r.last = it.lp;
            expected_points = {expected_points, r};
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk_pose(logic [47:0] t, logic signed [31:0] x, y, z,
                                    logic signed [15:0] roll, pitch);
    item_t it;
    it = '{pmpt_pkg::KIND_POSE, t, x, y, z, roll, pitch, 1'b0, 1'b0};
    return it;
  endfunction

  function automatic item_t mk_scan(logic [47:0] t);
    item_t it;
    it = '{pmpt_pkg::KIND_SCAN, t, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0};
    return it;
  endfunction

  function automatic item_t mk_point(logic signed [31:0] x, y, z, logic pv, lp);
    item_t it;
    it = '{pmpt_pkg::KIND_POINT, 48'({$urandom, $urandom}), x, y, z,
           16'($urandom), 16'($urandom), pv, lp};
    return it;
  endfunction

  // Called at a rising edge; returns at the accepting edge, or after a burst's idle gap.
  task automatic send_item(item_t it);
    in_valid <= 1;
    kind <= it.kind;
    time_us <= it.tus;
    coord_x <= it.x;
    coord_y <= it.y;
    coord_z <= it.z;
    tilt_roll <= it.roll;
    tilt_pitch <= it.pitch;
    point_valid <= it.pv;
    last_point <= it.lp;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(pmpt_pkg::reg_index_t idx, logic [pmpt_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    if (idx == pmpt_pkg::REG_USE_HISTORY) hist_on = val[0];
    else if (idx == pmpt_pkg::REG_STARTUP_SKIP) skip_cfg = val;
  endtask

  function automatic logic signed [31:0] rnd32();
    return 32'($urandom);
  endfunction

  // Startup skipping over a long count, and scans that find no pose.
  task automatic test_startup_skip();
    write_reg(pmpt_pkg::REG_SPARE2, 8'hFF);
    write_reg(pmpt_pkg::REG_STARTUP_SKIP, 8'd20);
    write_reg(pmpt_pkg::REG_USE_HISTORY, 8'd1);
    for (int i = 0; i < 21; i++) begin
      send_item(mk_scan(48'(i)));
      if (i % 8 == 0) send_item(mk_point(rnd32(), rnd32(), rnd32(), 1'b1, 1'b0));
    end
    send_item(mk_scan(48'd50));   // started, still no pose: ignored
    send_item(mk_point(rnd32(), rnd32(), rnd32(), 1'b1, 1'b0));
  endtask

  task automatic test_directed();
    send_item(mk_pose(48'd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0));
    send_item(mk_scan(48'd0));
    send_item(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0));
    send_item(mk_pose(48'd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                      16'sh7FFF, 16'sh8000));
    send_item(mk_pose(48'd200, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1,
                      16'sd12868, -16'sd12868));
    send_item(mk_pose(48'd300, 32'sd65536, -32'sd65536, 32'sd0, 16'sd12869, -16'sd12869));
    send_item(mk_scan(48'd250));
    send_item(mk_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0));
    send_item(mk_point(32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
    send_item(mk_point(-32'sd1, 32'sd1, -32'sd1, 1'b1, 1'b0));
    send_item(mk_point(32'sd65536, 32'sd65536, 32'sd65536, 1'b0, 1'b1));
    send_item(mk_point(32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b0));   // after end of scan
    send_item(mk_scan(TMAX));
    send_item(mk_point(32'sd131072, -32'sd98304, 32'sd1, 1'b1, 1'b1));
    send_item('{pmpt_pkg::KIND_NONE, TMAX, -32'sd1, -32'sd1, -32'sd1, -16'sd1, -16'sd1,
                1'b1, 1'b1});
    wait_all_results();
    write_reg(pmpt_pkg::REG_USE_HISTORY, 8'd0);
    send_item(mk_scan(48'd150));
    send_item(mk_point(32'sd65536, 32'sd0, 32'sd65536, 1'b1, 1'b1));
    now_t = 48'd1000;
  endtask

  // More poses than the ring holds, then a scan that searches most of it.
  task automatic test_ring_wrap();
    for (int i = 0; i < DEPTH + 8; i++) begin
      now_t += $urandom_range(1, 50);
      send_item(mk_pose(now_t, rnd32(), rnd32(), rnd32(), 16'($urandom), 16'($urandom)));
    end
    send_item(mk_scan(now_t - 48'd20));
    send_item(mk_point(rnd32(), rnd32(), rnd32(), 1'b1, 1'b1));
  endtask

  task automatic test_random_scans(int n_items);
    int sent, np;
    item_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        it = mk_point(rnd32(), rnd32(), rnd32(), 1'($urandom), 1'($urandom));
        it.kind = pmpt_pkg::kind_t'($urandom_range(1, 3));
        if (it.kind == pmpt_pkg::KIND_SCAN) it.tus = now_t - 48'($urandom_range(0, 2000));
        send_item(it);
        sent++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          now_t += $urandom_range(1, 500);
          send_item(mk_pose(now_t, rnd32(), rnd32(), rnd32(),
                            16'($urandom), 16'($urandom)));
          sent++;
        end
        send_item(mk_scan(now_t - 48'($urandom_range(0, 1500)) + 48'($urandom_range(0, 300))));
        np = $urandom_range(1, 8);
        for (int i = 0; i < np; i++) begin
          // most scans end on their final point; some end early or not at all
          send_item(mk_point(rnd32(), rnd32(), rnd32(), $urandom_range(0, 99) < 85,
                             (i == np - 1) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 29) == 0)));
        end
        sent += np + 1;
      end
    end
  endtask

  // receiver stall pattern
  int stall_mode = 0, stall_run = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run = $urandom_range(20, 200);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    point_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point result x=%h y=%h z=%h", out_x, out_y, out_z);
        fails++;
      end else begin
        e = expected_points.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %h got %h", e.x, out_x);
          fails++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %h got %h", e.y, out_y);
          fails++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %h got %h", e.z, out_z);
          fails++;
        end
        if (stamp_us !== e.stamp) begin
          $error("stamp_us expected %h got %h", e.stamp, stamp_us);
          fails++;
        end
        if (out_last !== e.last) begin
          $error("out_last expected %b got %b", e.last, out_last);
          fails++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wr_idx = '0;
    rd_idx = '0;
    skips_seen = '0;
    skip_cfg = pmpt_pkg::STARTUP_SKIP_RESET;
    hist_on = 0;
    have_pose = 0;
    started = 0;
    in_scan = 0;
    {sin_r, cos_r, sin_p, cos_p} = '0;
    {off_x, off_y, off_z} = '0;
    scan_stamp = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_startup_skip();
    test_directed();
    test_random_scans(100);
    wait_all_results();
    write_reg(pmpt_pkg::REG_USE_HISTORY, 8'd1);
    write_reg(pmpt_pkg::REG_STARTUP_SKIP, 8'd0);
    test_ring_wrap();
    test_random_scans(100);
    wait_all_results();
    write_reg(pmpt_pkg::REG_USE_HISTORY, 8'd0);
    test_random_scans(80);
    wait_all_results();
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/pmpt_pkg.sv
hw/rtl/pmpt_trig.sv
hw/rtl/pmpt_xform.sv
hw/rtl/pose_matched_point_transform.sv
verif/tb_pose_matched_point_transform.sv
